>>> rtl/cci_pkg.sv
package cci_pkg;

  // Fraction bits of the contact normal magnitude (Q1.29).
  localparam int NORM_BITS = 29;

  // Restitution of exactly one in Q1.16.
  localparam logic [16:0] REST_ONE = 17'h10000;

  // Operand and result widths of the shared arithmetic unit.
  localparam int OPA_W = 72;
  localparam int OPB_W = 36;

  // One body as delivered on the input channel.
  typedef struct packed {
    logic               second_body;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        radius;
    logic [31:0]        mass;
    logic               is_static;
    logic [16:0]        restitution;
  } body_word_t;

  // One resolved body as delivered on the output channel.
  typedef struct packed {
    logic               which_body;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [2:0]         outcome;
    logic               last_of_pair;
  } result_word_t;

  typedef enum logic [2:0] {
    OC_APART    = 3'd0,
    OC_COINC    = 3'd1,
    OC_STATIC   = 3'd2,
    OC_POS      = 3'd3,
    OC_POS_VEL  = 3'd4
  } outcome_t;

  // Micro-steps of one contact resolution, in execution order.
  typedef enum logic [4:0] {
    ST_DIFF, ST_ABS, ST_CHK_FAR, ST_SQX, ST_SQY, ST_SQR, ST_CMP, ST_CHK_CMP,
    ST_ROOT, ST_PEN, ST_NX, ST_NY, ST_CAM, ST_CAD, ST_CBM, ST_CBD,
    ST_PAX, ST_PAY, ST_PBX, ST_PBY, ST_DOTX, ST_DOTY, ST_CHK_DOT, ST_KM,
    ST_KAM, ST_KAD, ST_KBM, ST_KBD, ST_VAX, ST_VAY, ST_VBX, ST_VBY
  } step_t;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } arith_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_a;
    logic     load_b;
    logic     run;
    logic     start;
    step_t    step;
    logic     sel_b;
    outcome_t outcome;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic far;
    logic apart;
    logic coinc;
    logic both_static;
    logic separating;
  } stat_t;

  // True for steps that run on the shared arithmetic unit.
  function automatic logic step_uses_unit(input step_t s);
    case (s) inside
      ST_DIFF, ST_ABS, ST_CHK_FAR, ST_CMP, ST_CHK_CMP, ST_PEN, ST_CHK_DOT: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

endpackage

>>> rtl/cci_body_if.sv
interface cci_body_if;
  logic                  valid;
  logic                  ready;
  cci_pkg::body_word_t   data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/cci_result_if.sv
interface cci_result_if;
  logic                  valid;
  logic                  ready;
  cci_pkg::result_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/cci_arith.sv
module cci_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  cci_pkg::arith_op_t            op,
  input  logic [cci_pkg::OPA_W-1:0]     opa,
  input  logic [cci_pkg::OPB_W-1:0]     opb,
  output logic [cci_pkg::OPA_W-1:0]     res,
  output logic                          done
);

  localparam logic [4:0] MUL_LAST  = 5'd1;
  localparam logic [4:0] DIV_LAST  = 5'd17;
  localparam logic [4:0] SQRT_LAST = 5'd15;

  logic                 busy;
  logic                 done_r;
  cci_pkg::arith_op_t   op_r;
  logic [4:0]           cnt;
  logic [71:0]          acc;
  logic [71:0]          acc_next;
  logic [35:0]          mda;
  logic [35:0]          mdb;
  logic [34:0]          rem;
  logic [34:0]          rem_next;
  logic [71:0]          sh;
  logic [71:0]          sh_next;
  logic                 last;

  // One iteration: half a product, two quotient bits or two root bits.
  always_comb begin : iterate
    logic [53:0] pp;
    logic [33:0] t;
    logic [34:0] ts;
    logic [33:0] trial;
    logic [32:0] r;
    logic [71:0] s;
    logic [35:0] q;
    pp       = '0;
    r        = rem[32:0];
    s        = sh;
    q        = acc[35:0];
    acc_next = acc;
    rem_next = rem;
    sh_next  = sh;
    case (op_r)
      cci_pkg::AOP_MUL: begin
        pp = mda * (cnt[0] ? mdb[35:18] : mdb[17:0]);
        acc_next = acc + (cnt[0] ? {pp, 18'b0} : 72'(pp));
      end
      cci_pkg::AOP_DIV: begin
        for (int j = 0; j < 2; j++) begin
          t = {r, s[71]};
          s = {s[70:0], 1'b0};
          if (t >= {1'b0, mdb[32:0]}) begin
            r = 33'(t - {1'b0, mdb[32:0]});
            q = {q[34:0], 1'b1};
          end else begin
            r = t[32:0];
            q = {q[34:0], 1'b0};
          end
        end
        acc_next = 72'(q);
        rem_next = 35'(r);
        sh_next  = s;
      end
      cci_pkg::AOP_SQRT: begin
        for (int j = 0; j < 2; j++) begin
          ts    = {r, s[71:70]};
          s     = {s[69:0], 2'b00};
          trial = {q[31:0], 2'b01};
          if (ts >= 35'(trial)) begin
            r = 33'(ts - 35'(trial));
            q = {4'b0, q[30:0], 1'b1};
          end else begin
            r = ts[32:0];
            q = {4'b0, q[30:0], 1'b0};
          end
        end
        acc_next = 72'(q);
        rem_next = 35'(r);
        sh_next  = s;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (op_r)
      cci_pkg::AOP_MUL:  last = (cnt == MUL_LAST);
      cci_pkg::AOP_DIV:  last = (cnt == DIV_LAST);
      default:           last = (cnt == SQRT_LAST);
    endcase
  end

  // Operation sequencing and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        op_r <= op;
        cnt  <= '0;
        acc  <= '0;
        mda  <= opa[35:0];
        mdb  <= opb;
        case (op)
          cci_pkg::AOP_DIV: begin
            rem <= 35'(opa[68:36]);
            sh  <= {opa[35:0], 36'b0};
          end
          default: begin
            rem <= '0;
            sh  <= {opa[63:0], 8'b0};
          end
        endcase
      end else if (busy) begin
        acc <= acc_next;
        rem <= rem_next;
        sh  <= sh_next;
        cnt <= cnt + 5'd1;
        if (last) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res  = acc;
  assign done = done_r;

endmodule

>>> rtl/cci_dpath.sv
module cci_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  cci_pkg::body_word_t   in_data,
  input  cci_pkg::cmd_t         cmd,
  output cci_pkg::stat_t        stat,
  output cci_pkg::result_word_t out_data
);

  localparam logic signed [39:0] SAT_HI = 40'sh007FFFFFFF;
  localparam logic signed [39:0] SAT_LO = 40'shFF80000000;

  // Body registers; the first body is held here until its partner arrives.
  logic signed [31:0] a_px, a_py, a_vx, a_vy, b_px, b_py, b_vx, b_vy;
  logic [30:0]        a_r, b_r;
  logic [31:0]        a_m, b_m;
  logic               a_st, b_st;
  logic [16:0]        a_e, b_e;

  // Working registers of the resolution.
  logic signed [32:0] dx, dy, rvx, rvy;
  logic               fa, fb, negx, negy, svx, svy;
  logic [16:0]        emin;
  logic [31:0]        rsum;
  logic [32:0]        adx, ady, mvx, mvy;
  logic [63:0]        dx2, dy2, ssq, sumsq;
  logic               apart_f, coinc_f;
  logic [31:0]        gap, pen, na, nb, ca, cb;
  logic [32:0]        den;
  logic [29:0]        nxm, nym;
  logic signed [63:0] t1, dot;
  logic [34:0]        k, ka, kb;

  // Shared arithmetic unit.
  logic                        u_start;
  cci_pkg::arith_op_t          u_op;
  logic [cci_pkg::OPA_W-1:0]   u_opa;
  logic [cci_pkg::OPB_W-1:0]   u_opb;
  logic [cci_pkg::OPA_W-1:0]   res;
  logic                        u_done;

  logic [16:0]  ea, eb;
  logic [64:0]  sum65;
  logic [63:0]  dot_mag;
  logic [34:0]  vm;
  logic [35:0]  corr;

  function automatic logic [16:0] clamp_e(input logic [16:0] e);
    return (e > cci_pkg::REST_ONE) ? cci_pkg::REST_ONE : e;
  endfunction

  // Adds or subtracts a correction and saturates to 32 bits.
  function automatic logic signed [31:0] nudge(input logic signed [31:0] base,
                                               input logic neg, input logic [35:0] m);
    logic signed [39:0] step;
    logic signed [39:0] wide;
    step = signed'(40'(m));
    wide = neg ? (40'(base) - step) : (40'(base) + step);
    if (wide > SAT_HI) return 32'sh7FFFFFFF;
    if (wide < SAT_LO) return 32'sh80000000;
    return 32'(wide);
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic neg, input logic [62:0] m);
    logic signed [63:0] v;
    v = signed'({1'b0, m});
    return neg ? -v : v;
  endfunction

  cci_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .op    (u_op),
    .opa   (u_opa),
    .opb   (u_opb),
    .res   (res),
    .done  (u_done)
  );

  assign ea      = clamp_e(a_e);
  assign eb      = clamp_e(b_e);
  assign sum65   = 65'(dx2) + 65'(dy2);
  assign dot_mag = dot[63] ? 64'(-dot) : 64'(dot);
  assign vm      = dot_mag[63:29];
  assign corr    = res[64:29];

  // Operand selection for the arithmetic unit.
  always_comb begin
    u_start = cmd.start;
    u_op    = cci_pkg::AOP_MUL;
    u_opa   = '0;
    u_opb   = '0;
    unique case (cmd.step)
      cci_pkg::ST_SQX:  begin u_opa = 72'(adx);  u_opb = 36'(adx);  end
      cci_pkg::ST_SQY:  begin u_opa = 72'(ady);  u_opb = 36'(ady);  end
      cci_pkg::ST_SQR:  begin u_opa = 72'(rsum); u_opb = 36'(rsum); end
      cci_pkg::ST_ROOT: begin u_op = cci_pkg::AOP_SQRT; u_opa = 72'(sumsq); end
      cci_pkg::ST_NX: begin
        u_op  = cci_pkg::AOP_DIV;
        u_opa = 72'(adx[31:0]) << cci_pkg::NORM_BITS;
        u_opb = 36'(gap);
      end
      cci_pkg::ST_NY: begin
        u_op  = cci_pkg::AOP_DIV;
        u_opa = 72'(ady[31:0]) << cci_pkg::NORM_BITS;
        u_opb = 36'(gap);
      end
      cci_pkg::ST_CAM:  begin u_opa = 72'(pen); u_opb = 36'(na); end
      cci_pkg::ST_CBM:  begin u_opa = 72'(pen); u_opb = 36'(nb); end
      cci_pkg::ST_KAM:  begin u_opa = 72'(k);   u_opb = 36'(na); end
      cci_pkg::ST_KBM:  begin u_opa = 72'(k);   u_opb = 36'(nb); end
      cci_pkg::ST_CAD, cci_pkg::ST_CBD, cci_pkg::ST_KAD, cci_pkg::ST_KBD: begin
        u_op  = cci_pkg::AOP_DIV;
        u_opa = res;
        u_opb = 36'(den);
      end
      cci_pkg::ST_PAX:  begin u_opa = 72'(nxm); u_opb = 36'(ca); end
      cci_pkg::ST_PAY:  begin u_opa = 72'(nym); u_opb = 36'(ca); end
      cci_pkg::ST_PBX:  begin u_opa = 72'(nxm); u_opb = 36'(cb); end
      cci_pkg::ST_PBY:  begin u_opa = 72'(nym); u_opb = 36'(cb); end
      cci_pkg::ST_DOTX: begin u_opa = 72'(mvx); u_opb = 36'(nxm); end
      cci_pkg::ST_DOTY: begin u_opa = 72'(mvy); u_opb = 36'(nym); end
      cci_pkg::ST_KM: begin
        u_opa = 72'(vm);
        u_opb = 36'(18'(cci_pkg::REST_ONE) + 18'(emin));
      end
      cci_pkg::ST_VAX:  begin u_opa = 72'(nxm); u_opb = 36'(ka); end
      cci_pkg::ST_VAY:  begin u_opa = 72'(nym); u_opb = 36'(ka); end
      cci_pkg::ST_VBX:  begin u_opa = 72'(nxm); u_opb = 36'(kb); end
      cci_pkg::ST_VBY:  begin u_opa = 72'(nym); u_opb = 36'(kb); end
      default: ;
    endcase
  end

  // Body loads, steps that run without the arithmetic unit and writes of unit results.
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_px <= in_data.pos_x;
      a_py <= in_data.pos_y;
      a_vx <= in_data.vel_x;
      a_vy <= in_data.vel_y;
      a_r  <= in_data.radius;
      a_m  <= in_data.mass;
      a_st <= in_data.is_static;
      a_e  <= in_data.restitution;
    end
    if (cmd.load_b) begin
      b_px <= in_data.pos_x;
      b_py <= in_data.pos_y;
      b_vx <= in_data.vel_x;
      b_vy <= in_data.vel_y;
      b_r  <= in_data.radius;
      b_m  <= in_data.mass;
      b_st <= in_data.is_static;
      b_e  <= in_data.restitution;
    end
    if (cmd.run) begin
      unique case (cmd.step)
        cci_pkg::ST_DIFF: begin
          dx   <= 33'(a_px) - 33'(b_px);
          dy   <= 33'(a_py) - 33'(b_py);
          rvx  <= 33'(a_vx) - 33'(b_vx);
          rvy  <= 33'(a_vy) - 33'(b_vy);
          rsum <= 32'(a_r) + 32'(b_r);
          fa   <= a_st || (a_m == '0);
          fb   <= b_st || (b_m == '0);
          emin <= (ea < eb) ? ea : eb;
        end
        cci_pkg::ST_ABS: begin
          negx <= dx[32];
          negy <= dy[32];
          svx  <= rvx[32];
          svy  <= rvy[32];
          adx  <= dx[32]  ? 33'(-dx)  : 33'(dx);
          ady  <= dy[32]  ? 33'(-dy)  : 33'(dy);
          mvx  <= rvx[32] ? 33'(-rvx) : 33'(rvx);
          mvy  <= rvy[32] ? 33'(-rvy) : 33'(rvy);
        end
        cci_pkg::ST_CMP: begin
          sumsq   <= sum65[63:0];
          apart_f <= (sum65 >= 65'(ssq));
          coinc_f <= (sum65 == '0);
        end
        cci_pkg::ST_PEN: begin
          pen <= rsum - gap;
          if (fa) begin
            na  <= '0;
            nb  <= 32'd1;
            den <= 33'd1;
          end else if (fb) begin
            na  <= 32'd1;
            nb  <= '0;
            den <= 33'd1;
          end else begin
            na  <= b_m;
            nb  <= a_m;
            den <= 33'(a_m) + 33'(b_m);
          end
        end
        default: ;
      endcase
    end
    if (u_done) begin
      unique case (cmd.step)
        cci_pkg::ST_SQX:  dx2  <= res[63:0];
        cci_pkg::ST_SQY:  dy2  <= res[63:0];
        cci_pkg::ST_SQR:  ssq  <= res[63:0];
        cci_pkg::ST_ROOT: gap  <= res[31:0];
        cci_pkg::ST_NX:   nxm  <= res[29:0];
        cci_pkg::ST_NY:   nym  <= res[29:0];
        cci_pkg::ST_CAD:  ca   <= res[31:0];
        cci_pkg::ST_CBD:  cb   <= res[31:0];
        cci_pkg::ST_PAX:  a_px <= nudge(a_px, negx, corr);
        cci_pkg::ST_PAY:  a_py <= nudge(a_py, negy, corr);
        cci_pkg::ST_PBX:  b_px <= nudge(b_px, !negx, corr);
        cci_pkg::ST_PBY:  b_py <= nudge(b_py, !negy, corr);
        cci_pkg::ST_DOTX: t1   <= apply_sign(svx ^ negx, res[62:0]);
        cci_pkg::ST_DOTY: dot  <= t1 + apply_sign(svy ^ negy, res[62:0]);
        cci_pkg::ST_KM:   k    <= res[50:16];
        cci_pkg::ST_KAD:  ka   <= res[34:0];
        cci_pkg::ST_KBD:  kb   <= res[34:0];
        cci_pkg::ST_VAX:  a_vx <= nudge(a_vx, negx, corr);
        cci_pkg::ST_VAY:  a_vy <= nudge(a_vy, negy, corr);
        cci_pkg::ST_VBX:  b_vx <= nudge(b_vx, !negx, corr);
        cci_pkg::ST_VBY:  b_vy <= nudge(b_vy, !negy, corr);
        default: ;
      endcase
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.done        = u_done;
    stat.far         = (adx >= 33'(rsum)) || (ady >= 33'(rsum));
    stat.apart       = apart_f;
    stat.coinc       = coinc_f;
    stat.both_static = fa && fb;
    stat.separating  = (dot > 64'sd0);
  end

  // Result word: first body, then second body.
  always_comb begin
    out_data.which_body   = cmd.sel_b;
    out_data.new_pos_x    = cmd.sel_b ? b_px : a_px;
    out_data.new_pos_y    = cmd.sel_b ? b_py : a_py;
    out_data.new_vel_x    = cmd.sel_b ? b_vx : a_vx;
    out_data.new_vel_y    = cmd.sel_b ? b_vy : a_vy;
    out_data.outcome      = cmd.outcome;
    out_data.last_of_pair = cmd.sel_b;
  end

endmodule

>>> rtl/cci_ctrl.sv
module cci_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_second,
  output logic            out_valid,
  input  logic            out_ready,
  output cci_pkg::cmd_t   cmd,
  input  cci_pkg::stat_t  stat
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_OUT_A = 4'b0100,
    S_OUT_B = 4'b1000
  } state_t;

  state_t             state, state_next;
  cci_pkg::step_t     step, step_next;
  cci_pkg::outcome_t  outcome, outcome_next;
  logic               issued, issued_next;
  logic               have_first, have_first_next;
  logic               accept;
  logic               unit_step;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT_A) || (state == S_OUT_B);
  assign accept    = in_valid && in_ready;
  assign unit_step = cci_pkg::step_uses_unit(step);

  // Next-state logic: pair collection, step sequencing and result delivery.
  always_comb begin
    state_next      = state;
    step_next       = step;
    outcome_next    = outcome;
    issued_next     = issued;
    have_first_next = have_first;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!in_second) begin
            have_first_next = 1'b1;
          end else if (have_first) begin
            have_first_next = 1'b0;
            state_next      = S_CALC;
            step_next       = cci_pkg::ST_DIFF;
            issued_next     = 1'b0;
          end
        end
      end
      S_CALC: begin
        if (!unit_step) begin
          step_next = cci_pkg::step_t'(5'(step) + 5'd1);
          case (step)
            cci_pkg::ST_CHK_FAR: begin
              if (stat.far) begin
                state_next   = S_OUT_A;
                outcome_next = cci_pkg::OC_APART;
              end
            end
            cci_pkg::ST_CHK_CMP: begin
              if (stat.apart) begin
                state_next   = S_OUT_A;
                outcome_next = cci_pkg::OC_APART;
              end else if (stat.coinc) begin
                state_next   = S_OUT_A;
                outcome_next = cci_pkg::OC_COINC;
              end else if (stat.both_static) begin
                state_next   = S_OUT_A;
                outcome_next = cci_pkg::OC_STATIC;
              end
            end
            cci_pkg::ST_CHK_DOT: begin
              if (stat.separating) begin
                state_next   = S_OUT_A;
                outcome_next = cci_pkg::OC_POS;
              end
            end
            default: ;
          endcase
        end else if (stat.done) begin
          issued_next = 1'b0;
          if (step == cci_pkg::ST_VBY) begin
            state_next   = S_OUT_A;
            outcome_next = cci_pkg::OC_POS_VEL;
          end else begin
            step_next = cci_pkg::step_t'(5'(step) + 5'd1);
          end
        end else if (!issued) begin
          issued_next = 1'b1;
        end
      end
      S_OUT_A: begin
        if (out_ready) state_next = S_OUT_B;
      end
      S_OUT_B: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= cci_pkg::ST_DIFF;
      outcome    <= cci_pkg::OC_APART;
      issued     <= 1'b0;
      have_first <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      outcome    <= outcome_next;
      issued     <= issued_next;
      have_first <= have_first_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load_a  = accept && !in_second;
    cmd.load_b  = accept && in_second && have_first;
    cmd.run     = (state == S_CALC) && !unit_step;
    cmd.start   = (state == S_CALC) && unit_step && !issued;
    cmd.step    = step;
    cmd.sel_b   = (state == S_OUT_B);
    cmd.outcome = outcome;
  end

endmodule

>>> rtl/circle_contact_impulse_resolver.sv
// Contact resolver for two circular bodies in Q16.16 fixed point.
// body_in carries one body per word. A word with second_body low is held as
// the first body of a pair (a later one replaces it). A word with
// second_body high resolves the contact against the held body; without a
// held body it is dropped. Each resolved pair gives two words on
// result_out: the first body, then the second body with last_of_pair set.
// After the second body is taken, the resolution ends early for a pair
// apart on one axis alone, a pair apart by the squared distance, a
// coincident or fully static pair, or a separating pair, and otherwise
// runs the full impulse resolution. Its length is set by the single
// shared arithmetic unit, which runs the multiplies, the divides (two
// quotient bits a cycle) and the square root.
// body_in is ready only while no pair is being resolved or delivered.
// If result_out stalls, the result word is held steady until taken and no
// new body is accepted. Reset clears the held-body flag and returns the
// block to idle; held body fields keep no reset value.
module circle_contact_impulse_resolver (
  input  logic          clk,
  input  logic          rst,
  cci_body_if.sink      body_in,
  cci_result_if.source  result_out
);

  cci_pkg::cmd_t  cmd;
  cci_pkg::stat_t stat;

  cci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (body_in.valid),
    .in_ready  (body_in.ready),
    .in_second (body_in.data.second_body),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cci_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (body_in.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (result_out.data)
  );

endmodule
